// ----- hw/rtl/idq_pkg.sv -----
package idq_pkg;

   // Field widths of the stream items
   localparam int ACTION_W   = 3;
   localparam int ID_FIELD_W = 16;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 4;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEF    = 16;
   localparam int ID_WIDTH_DEF = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_REMOVE     = 3'd4,
      ACT_LOOKUP     = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_DATA,
      S_SEARCH,
      S_SHIFT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0]      position;
      status_type            status;
      logic [ID_FIELD_W-1:0] result_id;
   } result_type;

endpackage

// ----- hw/rtl/idq_ram.sv -----
module idq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/idq_stepper.sv -----
module idq_stepper #(
   parameter int DEPTH = 16
) (
   input  logic [$clog2(DEPTH)-1:0] ptr,
   input  logic                     up,
   output logic [$clog2(DEPTH)-1:0] ptr_next
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   // Advance or retreat a ring pointer, wrapping at the store depth
   always_comb begin
      if (up) begin
         ptr_next = (ptr == LAST) ? '0 : ptr + 1'b1;
      end else begin
         ptr_next = (ptr == '0) ? LAST : ptr - 1'b1;
      end
   end

endmodule

// ----- hw/rtl/idq_seq.sv -----
module idq_seq #(
   parameter int DEPTH    = 16,
   parameter int ID_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  idq_pkg::action_type                req_action,
   input  logic [idq_pkg::ID_FIELD_W-1:0]     req_entry_id,
   output logic                               res_valid,
   output idq_pkg::result_type                res,
   input  logic                               res_take
);

   import idq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [ID_WIDTH-1:0] key_ff, key_in;
   action_type        action_ff, action_in;
   logic [AW-1:0]     walk_ptr_ff, walk_ptr_in;
   logic [CW-1:0]     walk_idx_ff, walk_idx_in;
   logic [AW-1:0]     hit_ptr_ff, hit_ptr_in;
   logic [CW-1:0]     hit_idx_ff, hit_idx_in;
   logic              hit_valid_ff, hit_valid_in;
   result_type        res_ff, res_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [ID_WIDTH-1:0]       wr_data;
   logic [AW-1:0]             rd_addr;
   logic [ID_WIDTH-1:0]       rd_data;
   logic [AW-1:0]             step_ptr;
   logic                      step_up;
   logic [AW-1:0]             step_out;

   logic [ID_WIDTH+ID_FIELD_W-1:0] key_ext;
   logic [ID_WIDTH-1:0]            key_new;
   logic [ID_WIDTH+ID_FIELD_W-1:0] rid_ext;
   logic [ID_FIELD_W-1:0]          rid;
   logic [CW+POS_W-1:0]            pos_ext;
   logic [POS_W-1:0]               pos;
   logic                           full;
   logic                           empty;
   logic                           hit;

   // Identifier store, one entry per ring slot
   idq_ram #(
      .WIDTH(ID_WIDTH),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Shared ring pointer stepper
   idq_stepper #(
      .DEPTH(DEPTH)
   ) u_step (
      .ptr     (step_ptr),
      .up      (step_up),
      .ptr_next(step_out)
   );

   // Fit identifiers between field width and storage width
   assign key_ext = {ID_WIDTH'(0), req_entry_id};
   assign key_new = key_ext[ID_WIDTH-1:0];
   assign rid_ext = {ID_FIELD_W'(0), rd_data};
   assign rid     = rid_ext[ID_FIELD_W-1:0];
   assign pos_ext = {POS_W'(0), hit_idx_ff};
   assign pos     = pos_ext[POS_W-1:0];

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign hit   = hit_valid_ff && (rd_data == key_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Ring pointers, count, request, walk and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         hit_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         hit_valid_ff <= hit_valid_in;
      end
      key_ff      <= key_in;
      action_ff   <= action_in;
      walk_ptr_ff <= walk_ptr_in;
      walk_idx_ff <= walk_idx_in;
      hit_ptr_ff  <= hit_ptr_in;
      hit_idx_ff  <= hit_idx_in;
      res_ff      <= res_in;
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      action_in    = action_ff;
      walk_ptr_in  = walk_ptr_ff;
      walk_idx_in  = walk_idx_ff;
      hit_ptr_in   = hit_ptr_ff;
      hit_idx_in   = hit_idx_ff;
      hit_valid_in = 1'b0;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = key_ff;
      rd_addr      = head_ff;
      step_ptr     = head_ff;
      step_up      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in           = key_new;
               action_in        = req_action;
               walk_ptr_in      = head_ff;
               walk_idx_in      = '0;
               res_in.result_id = '0;
               res_in.status    = ST_OK;
               res_in.position  = '0;
               state_in         = S_DONE;
               unique case (req_action) inside
                  ACT_PUSH_FRONT: begin
                     if (full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        step_ptr = head_ff;
                        step_up  = 1'b0;
                        head_in  = step_out;
                        wr_en    = 1'b1;
                        wr_addr  = step_out;
                        wr_data  = key_new;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_PUSH_BACK: begin
                     if (full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        step_ptr = tail_ff;
                        tail_in  = step_out;
                        wr_en    = 1'b1;
                        wr_addr  = tail_ff;
                        wr_data  = key_new;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        rd_addr  = head_ff;
                        step_ptr = head_ff;
                        head_in  = step_out;
                        count_in = count_ff - 1'b1;
                        state_in = S_POP_DATA;
                     end
                  end
                  ACT_POP_BACK: begin
                     if (empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        step_ptr = tail_ff;
                        step_up  = 1'b0;
                        rd_addr  = step_out;
                        tail_in  = step_out;
                        count_in = count_ff - 1'b1;
                        state_in = S_POP_DATA;
                     end
                  end
                  ACT_REMOVE, ACT_LOOKUP: begin
                     state_in = S_SEARCH;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_POP_DATA: begin
            res_in.result_id = rid;
            state_in         = S_DONE;
         end

         S_SEARCH: begin
            if (hit) begin
               // Match: report it, then close up the gap on a remove
               res_in.result_id = rid;
               res_in.position  = pos;
               res_in.status    = ST_OK;
               if (action_ff == ACT_LOOKUP) begin
                  state_in = S_DONE;
               end else if ((hit_idx_ff + CW'(1)) < count_ff) begin
                  rd_addr  = walk_ptr_ff;
                  state_in = S_SHIFT;
               end else begin
                  step_ptr = tail_ff;
                  step_up  = 1'b0;
                  tail_in  = step_out;
                  count_in = count_ff - 1'b1;
                  state_in = S_DONE;
               end
            end else if (walk_idx_ff < count_ff) begin
               // Issue the next read while the previous entry is compared
               rd_addr      = walk_ptr_ff;
               hit_valid_in = 1'b1;
               hit_ptr_in   = walk_ptr_ff;
               hit_idx_in   = walk_idx_ff;
               step_ptr     = walk_ptr_ff;
               walk_ptr_in  = step_out;
               walk_idx_in  = walk_idx_ff + 1'b1;
            end else if (!hit_valid_ff) begin
               res_in.result_id = '0;
               res_in.position  = '0;
               res_in.status    = ST_NOT_FOUND;
               state_in         = S_DONE;
            end
         end

         S_SHIFT: begin
            // Move the entry just read one slot toward the front
            wr_en   = 1'b1;
            wr_addr = hit_ptr_ff;
            wr_data = rd_data;
            if ((walk_idx_ff + CW'(1)) < count_ff) begin
               step_ptr    = walk_ptr_ff;
               rd_addr     = step_out;
               hit_ptr_in  = walk_ptr_ff;
               walk_ptr_in = step_out;
               walk_idx_in = walk_idx_ff + 1'b1;
            end else begin
               step_ptr = tail_ff;
               step_up  = 1'b0;
               tail_in  = step_out;
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/id_deque_with_remove.sv -----
// Channel | Dir | Bus fields (lowest bit first)
// req_    | in  | tuser: action[2:0]; tdata: entry_id[15:0]
// rsp_    | out | tuser: status[1:0]; tdata: result_id[15:0], position[19:16], zero[23:20]
//
// Pushes, refused pushes, pops of an empty store and unknown actions go straight to the result;
// other pops first read the popped entry from the entry RAM.
// Lookup and remove walk the entry RAM one entry per cycle through its single read port;
// a remove hit then moves each later entry one slot toward the front.
// Reset is synchronous; the store holds no valid entries after it.
// The result sits in an output register, so the next item is taken while it waits;
// a second finished result waits until that register is free.
module id_deque_with_remove #(
   parameter int DEPTH    = idq_pkg::DEPTH_DEF,
   parameter int ID_WIDTH = idq_pkg::ID_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // entry_id[15:0]
   input  logic [2:0]  req_tuser,   // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // result_id[15:0], position[19:16], zero pad[23:20]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   import idq_pkg::*;

   logic       res_valid;
   result_type res;
   logic       res_take;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   idq_seq #(
      .DEPTH   (DEPTH),
      .ID_WIDTH(ID_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_action  (action_type'(req_tuser)),
      .req_entry_id(req_tdata),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take)
   );

   // Load the output register when it is empty or being drained
   always_comb begin
      res_take     = res_valid && (!rsp_valid_ff || rsp_tready);
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff.position, rsp_data_ff.result_id};
   assign rsp_tuser  = rsp_data_ff.status;

endmodule

// ----- hw/rtl/idq_checker.sv -----
module idq_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   import idq_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Drop ready in the cycle after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while busy");

   // Carry no identifier or position on a failed operation
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == 24'd0)
      else $error("failed operation carries data");

   // Come out of reset idle and ready with no result pending
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind id_deque_with_remove idq_port_checks u_idq_checker (.*);

// ----- sim/idq_checker.sv -----
`timescale 1ns / 100ps

module idq_checker #(
   parameter int DEPTH    = idq_pkg::DEPTH_DEF,
   parameter int ID_WIDTH = idq_pkg::ID_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // entry_id[15:0]
   input  logic [2:0]  req_tuser,   // action[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // result_id[15:0], position[19:16], zero pad[23:20]
   input  logic [1:0]  rsp_tuser,   // status[1:0]
   output int          fail_count,
   output int          pending_count
);

   import idq_pkg::*;

   localparam logic [ID_FIELD_W-1:0] ID_MASK = ID_FIELD_W'((64'd1 << ID_WIDTH) - 64'd1);

   // Shadow copy of the identifier list, front at index 0
   logic [ID_FIELD_W-1:0] id_list [$];
   // Results still owed by the block, oldest first
   result_type            owed_results [$];
   result_type            want_r;
   result_type            got_r;
   int                    errors = 0;

   // Apply one operation to the shadow list and return the result it should give
   function automatic result_type apply_op(input logic [2:0] act,
                                           input logic [ID_FIELD_W-1:0] raw_id);
      result_type            r;
      logic [ID_FIELD_W-1:0] key;
      int                    hit;
      int                    i;
      r   = '0;
      key = raw_id & ID_MASK;
      hit = -1;
      case (act) inside
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (id_list.size() >= DEPTH)
               r.status = ST_FULL;
            else if (act == ACT_PUSH_FRONT)
               id_list = {key, id_list};
            else
               id_list = {id_list, key};
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (id_list.size() == 0) begin
               r.status = ST_EMPTY;
            end else if (act == ACT_POP_FRONT) begin
               r.result_id = id_list[0];
               id_list.delete(0);
            end else begin
               r.result_id = id_list[$];
               id_list.delete(id_list.size() - 1);
            end
         end
         ACT_REMOVE, ACT_LOOKUP: begin
            // first match from the front wins
            for (i = 0; i < id_list.size() && hit < 0; i++) begin
               if (id_list[i] == key)
                  hit = i;
            end
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               r.result_id = id_list[hit];
               r.position  = POS_W'(hit);
               if (act == ACT_REMOVE)
                  id_list.delete(hit);
            end
         end
         default: begin
            // unused codes give an all-zero result and leave the list alone
         end
      endcase
      return r;
   endfunction

   task automatic report_field(input string what, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: rsp %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
         errors++;
      end
   endtask

   // Predict on each accepted request, compare each accepted response
   always @(posedge clock) begin
      if (reset) begin
         id_list.delete();
         owed_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            owed_results = {owed_results, apply_op(req_tuser, req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            got_r.result_id = rsp_tdata[15:0];
            got_r.position  = rsp_tdata[19:16];
            got_r.status    = status_type'(rsp_tuser);
            if (owed_results.size() == 0) begin
               $display("%0t: rsp item with none expected: id 0x%0h status %0d pos %0d",
                        $time, got_r.result_id, got_r.status, got_r.position);
               errors++;
            end else begin
               want_r = owed_results[0];
               owed_results.delete(0);
               report_field("result_id", want_r.result_id, got_r.result_id);
               report_field("status", want_r.status, got_r.status);
               report_field("position", want_r.position, got_r.position);
               report_field("pad", 0, rsp_tdata[23:20]);
            end
         end
      end
      fail_count    <= errors;
      pending_count <= owed_results.size();
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import idq_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int QUIET_ITEMS  = 80;

   // Action codes the block does not use
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   typedef enum logic [1:0] {
      MODE_FILL,
      MODE_DRAIN,
      MODE_SEARCH,
      MODE_MIX
   } run_mode_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // entry_id[15:0]
   logic [2:0]  req_tuser  = '0;   // action[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;         // result_id[15:0], position[19:16], zero pad[23:20]
   logic [1:0]  rsp_tuser;         // status[1:0]
   int          fail_count;
   int          pending_count;

   bit          quiet  = 1'b0;
   bit          gap_on = 1'b0;
   bit          stall_on = 1'b1;
   int          stall_left = 0;
   int          window_cnt = 0;
   logic [15:0] id_pool [8];

   id_deque_with_remove i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   idq_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop if the run hangs
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Stall the response side in bursts, with calm windows between
   always @(posedge clock) begin
      window_cnt <= window_cnt + 1;
      if (window_cnt % 128 == 0)
         stall_on <= ($urandom_range(0, 2) != 0);
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one item, maybe after an idle burst, and hold it until taken
   task automatic send_item(input logic [2:0] act, input logic [15:0] id);
      if (gap_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= id;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off until the block has answered everything
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Mostly reuse a few ids so removes and lookups hit, sometimes any value
   function automatic logic [15:0] pick_id();
      if ($urandom_range(0, 3) != 0)
         return id_pool[$urandom_range(0, 7)];
      return 16'($urandom);
   endfunction

   function automatic logic [2:0] pick_action(input run_mode_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         return (roll == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
      case (mode)
         MODE_FILL: begin
            if (roll < 40) return ACT_PUSH_FRONT;
            if (roll < 75) return ACT_PUSH_BACK;
            if (roll < 85) return ACT_LOOKUP;
            if (roll < 92) return ACT_REMOVE;
            if (roll < 96) return ACT_POP_FRONT;
            return ACT_POP_BACK;
         end
         MODE_DRAIN: begin
            if (roll < 38) return ACT_POP_FRONT;
            if (roll < 72) return ACT_POP_BACK;
            if (roll < 80) return ACT_PUSH_BACK;
            if (roll < 87) return ACT_PUSH_FRONT;
            if (roll < 94) return ACT_REMOVE;
            return ACT_LOOKUP;
         end
         MODE_SEARCH: begin
            if (roll < 32) return ACT_REMOVE;
            if (roll < 60) return ACT_LOOKUP;
            if (roll < 75) return ACT_PUSH_BACK;
            if (roll < 86) return ACT_PUSH_FRONT;
            if (roll < 93) return ACT_POP_FRONT;
            return ACT_POP_BACK;
         end
         default: begin
            if (roll < 19) return ACT_PUSH_FRONT;
            if (roll < 36) return ACT_PUSH_BACK;
            if (roll < 52) return ACT_POP_FRONT;
            if (roll < 68) return ACT_POP_BACK;
            if (roll < 84) return ACT_REMOVE;
            return ACT_LOOKUP;
         end
      endcase
   endfunction

   initial begin
      int           sent;
      int           seg_len;
      int           k;
      bit           drained;
      logic [2:0]   act;
      run_mode_type mode;

      foreach (id_pool[n])
         id_pool[n] = 16'($urandom);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty store: pops, misses and the unused codes
      send_item(ACT_POP_FRONT, 16'h0000);
      send_item(ACT_POP_BACK, 16'hFFFF);
      send_item(ACT_REMOVE, 16'h0000);
      send_item(ACT_LOOKUP, 16'hFFFF);
      send_item(ACT_SPARE_LO, 16'hFFFF);
      send_item(ACT_SPARE_HI, 16'h0000);

      // Fill to capacity with a duplicate id, then push into the full store
      send_item(ACT_PUSH_FRONT, 16'hFFFF);
      for (k = 0; k < 14; k++)
         send_item(ACT_PUSH_BACK, 16'(k * 16'h1111));
      send_item(ACT_PUSH_FRONT, 16'h0000);
      send_item(ACT_PUSH_BACK, 16'h5555);
      send_item(ACT_PUSH_FRONT, 16'hAAAA);

      // Hits at both ends, first-match remove, pops and misses
      send_item(ACT_LOOKUP, 16'hDDDD);
      send_item(ACT_LOOKUP, 16'h0000);
      send_item(ACT_REMOVE, 16'h0000);
      send_item(ACT_REMOVE, 16'hDDDD);
      send_item(ACT_POP_BACK, 16'h0000);
      send_item(ACT_POP_FRONT, 16'h0000);
      send_item(ACT_LOOKUP, 16'hABCD);
      send_item(ACT_REMOVE, 16'hABCD);

      // Random segments, each biased toward filling, draining or searching, or mixed
      sent    = 0;
      drained = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         mode    = run_mode_type'($urandom_range(0, 3));
         seg_len = $urandom_range(8, 40);
         gap_on  = ($urandom_range(0, 2) != 0);
         if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
         for (k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
            act = pick_action(mode);
            send_item(act, pick_id());
            if (act <= ACT_LOOKUP)
               sent++;
         end
         if (!quiet && ((!drained && sent >= RANDOM_ITEMS / 2) || $urandom_range(0, 7) == 0)) begin
            drain_responses();
            drained = 1'b1;
         end
      end

      // Wait out the last responses, then give the verdict
      drain_responses();
      repeat (64) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/idq_pkg.sv
hw/rtl/idq_ram.sv
hw/rtl/idq_stepper.sv
hw/rtl/idq_seq.sv
hw/rtl/id_deque_with_remove.sv
hw/rtl/idq_checker.sv
sim/idq_checker.sv
sim/tb_top.sv
